[src/abad_pkg.sv]
// Package for the adaptive binary arithmetic decoder.
// Holds the channel word types, the controller/datapath command and status
// structs and the fixed coder constants. No dependencies.
package abad_pkg;

  // Width of the code range and low registers.
  localparam int unsigned RangeWidth = 16;
  // One stream byte and the radix that renormalisation scales by.
  localparam int unsigned ByteBits = 8;
  localparam int unsigned ByteRadix = 256;
  // Width of the context index field on the input word.
  localparam int unsigned CtxFieldWidth = 6;
  localparam int unsigned CtxFieldCount = 64;
  // The quotient is below the range, so one step per range bit suffices.
  localparam int unsigned DivSteps = RangeWidth;
  localparam int unsigned StepWidth = $clog2(DivSteps);

  // Input word: one decode request.
  typedef struct packed {
    logic [CtxFieldWidth-1:0] context_index;
    logic [ByteBits-1:0]      next_byte;
    logic                     byte_present;
  } in_word_t;

  // Output word: one decoded bit.
  typedef struct packed {
    logic decoded_bit;
    logic byte_consumed;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;     // write zero counts at the clear address
    logic start;      // latch the request, renormalise, read the counts
    logic mul;        // form the dividend and seed the divider
    logic div_step;   // one restoring division step
    logic update;     // pick the bit, update range, low and counts
    logic load_out;   // move the result into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // the clear pass is at its final entry
  } dp_status_t;

endpackage

[src/abad_ram.sv]
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module abad_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/abad_datapath.sv]
// Datapath of the adaptive binary arithmetic decoder: code registers,
// count memory, multiplier, serial divider and output register.
// Depends on abad_pkg and abad_ram.
module abad_datapath #(
  parameter int unsigned CONTEXT_COUNT = 64,
  parameter int unsigned COUNT_LIMIT = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abad_pkg::ctl_cmd_t  cmd_i,
  output abad_pkg::dp_status_t status_o,
  input  abad_pkg::in_word_t  in_word_i,
  output abad_pkg::out_word_t out_word_o
);

  localparam int unsigned AddrWidth = $clog2(CONTEXT_COUNT);
  // A single count never exceeds COUNT_LIMIT - 1 once stored.
  localparam int unsigned CntWidth = $clog2(COUNT_LIMIT);
  // The total count + 2 reaches at most COUNT_LIMIT + 1.
  localparam int unsigned TotWidth = $clog2(COUNT_LIMIT + 2);
  localparam int unsigned ProdWidth = abad_pkg::RangeWidth + TotWidth;
  localparam int unsigned RW = abad_pkg::RangeWidth;
  localparam int unsigned BW = abad_pkg::ByteBits;

  // Context wrap table: index modulo the context count.
  logic [AddrWidth-1:0] wrap_tbl [abad_pkg::CtxFieldCount];

  for (genvar i = 0; i < abad_pkg::CtxFieldCount; i++) begin : g_wrap
    localparam int unsigned Wrapped = i % CONTEXT_COUNT;
    assign wrap_tbl[i] = AddrWidth'(Wrapped);
  end

  logic [AddrWidth-1:0] clr_addr_q, clr_addr_d;
  logic [AddrWidth-1:0] ctx_q, ctx_d;
  logic [RW-1:0]        range_q, range_d;
  logic [RW-1:0]        low_q, low_d;
  logic                 consumed_q, consumed_d;
  logic [CntWidth-1:0]  n0_q, n0_d, n1_q, n1_d;
  logic [TotWidth-1:0]  total_q, total_d;
  logic [TotWidth-1:0]  rem_q, rem_d;
  logic [RW-1:0]        quo_q, quo_d;
  logic                 bit_q, bit_d;
  abad_pkg::out_word_t  out_q, out_d;

  logic [2*CntWidth-1:0] rd_data;
  logic [2*CntWidth-1:0] wr_data;
  logic [AddrWidth-1:0]  wr_addr;
  logic                  wr_en;

  logic [CntWidth-1:0]  rd_n0, rd_n1;
  logic [TotWidth-1:0]  lowpart;
  logic [TotWidth-1:0]  total;
  logic [ProdWidth-1:0] product;
  logic [TotWidth:0]    trial;
  logic                 trial_ge;
  logic                 dec_bit;
  logic [CntWidth:0]    n0_inc, n1_inc;
  logic                 halve;

  assign rd_n0 = rd_data[CntWidth-1:0];
  assign rd_n1 = rd_data[2*CntWidth-1:CntWidth];

  // Split operands and dividend straight from the memory output.
  assign lowpart = TotWidth'(rd_n0) + TotWidth'(1);
  assign total   = TotWidth'(rd_n0) + TotWidth'(rd_n1) + TotWidth'(2);
  assign product = ProdWidth'(range_q) * ProdWidth'(lowpart);

  // One restoring division step: bring in the next dividend bit.
  assign trial    = {rem_q, quo_q[RW-1]};
  assign trial_ge = (trial >= {1'b0, total_q});

  // Bit decision and count adaptation on the finished quotient.
  assign dec_bit = (low_q >= quo_q);
  assign n0_inc  = (CntWidth + 1)'(n0_q) + (CntWidth + 1)'(!dec_bit);
  assign n1_inc  = (CntWidth + 1)'(n1_q) + (CntWidth + 1)'(dec_bit);
  assign halve   = (total_q > TotWidth'(COUNT_LIMIT));

  // Memory write: zeros during the clear pass, new counts on update.
  assign wr_en   = cmd_i.clr_wr | cmd_i.update;
  assign wr_addr = cmd_i.clr_wr ? clr_addr_q : ctx_q;
  always_comb begin
    wr_data = '0;
    if (!cmd_i.clr_wr) begin
      wr_data[CntWidth-1:0] =
        halve ? n0_inc[CntWidth:1] : n0_inc[CntWidth-1:0];
      wr_data[2*CntWidth-1:CntWidth] =
        halve ? n1_inc[CntWidth:1] : n1_inc[CntWidth-1:0];
    end
  end

  abad_ram #(
    .Width (2 * CntWidth),
    .Depth (CONTEXT_COUNT)
  ) u_count_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.start),
    .rd_addr_i (wrap_tbl[in_word_i.context_index]),
    .rd_data_o (rd_data)
  );

  // Next-state logic for the datapath registers.
  always_comb begin
    clr_addr_d = clr_addr_q;
    ctx_d      = ctx_q;
    range_d    = range_q;
    low_d      = low_q;
    consumed_d = consumed_q;
    n0_d       = n0_q;
    n1_d       = n1_q;
    total_d    = total_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    bit_d      = bit_q;
    out_d      = out_q;

    if (cmd_i.clr_wr) begin
      clr_addr_d = clr_addr_q + AddrWidth'(1);
    end

    // Accept a request and renormalise when the range has run low.
    if (cmd_i.start) begin
      ctx_d      = wrap_tbl[in_word_i.context_index];
      consumed_d = 1'b0;
      if (range_q < RW'(abad_pkg::ByteRadix)) begin
        range_d = {range_q[RW-BW-1:0], {BW{1'b0}}};
        low_d   = {low_q[RW-BW-1:0], {BW{1'b0}}};
        if (in_word_i.byte_present) begin
          low_d[BW-1:0] = in_word_i.next_byte;
          consumed_d    = 1'b1;
        end
      end
    end

    // Dividend = range * (count0 + 1); its top part seeds the remainder.
    if (cmd_i.mul) begin
      n0_d    = rd_n0;
      n1_d    = rd_n1;
      total_d = total;
      rem_d   = product[ProdWidth-1:RW];
      quo_d   = product[RW-1:0];
    end

    if (cmd_i.div_step) begin
      rem_d = trial_ge ? TotWidth'(trial - {1'b0, total_q}) : trial[TotWidth-1:0];
      quo_d = {quo_q[RW-2:0], trial_ge};
    end

    // The quotient is the split point; narrow the interval to one side.
    if (cmd_i.update) begin
      bit_d = dec_bit;
      if (dec_bit) begin
        low_d   = low_q - quo_q;
        range_d = range_q - quo_q;
      end else begin
        range_d = quo_q;
      end
    end

    if (cmd_i.load_out) begin
      out_d.decoded_bit   = bit_q;
      out_d.byte_consumed = consumed_q;
    end
  end

  // Coding state and the clear address need a defined start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      range_q    <= RW'(1);
      low_q      <= '0;
    end else begin
      clr_addr_q <= clr_addr_d;
      range_q    <= range_d;
      low_q      <= low_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ctx_q      <= ctx_d;
    consumed_q <= consumed_d;
    n0_q       <= n0_d;
    n1_q       <= n1_d;
    total_q    <= total_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    bit_q      <= bit_d;
    out_q      <= out_d;
  end

  assign status_o.clr_last = (clr_addr_q == AddrWidth'(CONTEXT_COUNT - 1));
  assign out_word_o        = out_q;

endmodule

[src/abad_ctrl.sv]
// Controller of the adaptive binary arithmetic decoder: sequences the
// clear pass, the multiply, the division steps and the output handshake.
// Depends on abad_pkg.
module abad_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  abad_pkg::dp_status_t status_i,
  output abad_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul,
    StDiv,
    StUpdate,
    StDone
  } state_e;

  state_e                             state_q, state_d;
  logic [abad_pkg::StepWidth-1:0]     step_q, step_d;
  logic                               out_valid_q, out_valid_d;

  // Next state, step count and commands.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        step_d    = '0;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + abad_pkg::StepWidth'(1);
        if (step_q == abad_pkg::StepWidth'(abad_pkg::DivSteps - 1)) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

[src/adaptive_binary_arith_decoder_top.sv]
// Top level of the adaptive binary arithmetic decoder.
// Depends on abad_pkg, abad_ctrl and abad_datapath.
//
//   Channel | Direction | Handshake             | Word
//   --------+-----------+-----------------------+---------------------------
//   input   | in        | in_valid_i/in_ready_o | in_word_i  (in_word_t)
//   output  | out       | out_valid_o/out_ready_i | out_word_o (out_word_t)
//
// A request passes in order through renormalisation and the count read, the
// multiply, 16 steps of the serial divider that forms the split point, the
// update and the output transfer.
// After reset a clearing pass writes zero counts to all CONTEXT_COUNT contexts,
// one context per cycle; no request is accepted until it ends.
// A result waits in the output register while the next request is taken in;
// a new result is held back only while the previous one is still unread.
module adaptive_binary_arith_decoder_top #(
  parameter int unsigned CONTEXT_COUNT = 64,
  parameter int unsigned COUNT_LIMIT = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  abad_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output abad_pkg::out_word_t out_word_o
);

  abad_pkg::ctl_cmd_t   cmd;
  abad_pkg::dp_status_t status;

  abad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  abad_datapath #(
    .CONTEXT_COUNT (CONTEXT_COUNT),
    .COUNT_LIMIT   (COUNT_LIMIT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule
